// ===== sv/tpb_pkg.sv =====
// Package for the thermal PID power budget unit: coefficient kinds, table
// geometry, sequencer states and arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
package tpb_pkg;
  localparam int NUM_LEVELS_DEF = 7;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int KINDS = 10;
  localparam int LVL_W = 3;
  localparam int KIND_W = 4;

  typedef enum logic [3:0] {
    K_THR = 4'd0, K_KPO = 4'd1, K_KPU = 4'd2, K_KI = 4'd3, K_KD = 4'd4,
    K_ICUT = 4'd5, K_IMAX = 4'd6, K_BASE = 4'd7, K_MIN = 4'd8, K_MAX = 4'd9
  } coef_kind_t;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_THR, S_ERR, S_KP, S_P, S_RD_KI, S_I0, S_RD_ICUT, S_N, S_IN,
    S_RD_IMAX, S_IMAX, S_RD_KD, S_KD, S_DIV, S_D, S_RD_BASE, S_BASE,
    S_RD_MIN, S_MIN, S_RD_MAX, S_MAX, S_OUT
  } state_t;

  function automatic logic signed [63:0] floor_shr24(input logic signed [63:0] x);
    floor_shr24 = x >>> 24;
  endfunction
endpackage

// ===== sv/tpb_divider.sv =====
// Restoring divider, one quotient bit per cycle, truncating signed quotient.
// Self-contained; no package dependencies.
`timescale 1ns / 1ps
module tpb_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic        [15:0] divisor,
  output logic               done,
  output logic signed [63:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; neg_nxt = neg_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[63]};
    if (start) begin
      neg_nxt = dividend[63];
      q_nxt = dividend[63] ? 64'(-dividend) : 64'(dividend);
      rem_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = 16'(trial - {1'b0, divisor});
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

// ===== sv/thermal_pid_power_budget_unit.sv =====
// Thermal PID power budget unit, top level: coefficient memory, sequencer,
// multiply steps and divider. Depends on tpb_pkg and tpb_divider.
//
//  channel | direction | handshake       | payload
//  in_     | input     | in_valid/stall  | opcode..coef_value
//  out_    | output    | out_valid/stall | budget_mw..budget_valid
//  cfg_    | input     | cfg_we          | level_enable_mask
//
// A load or a severity-zero sample returns its result the cycle after transfer.
// A sample gives its result once the sequencer returns to idle; the derivative
// divide runs only with a previous error and nonzero elapsed_ms, the integral
// limit check only for an error below K_ICUT; the 64-step divide is the longest.
// Reset is synchronous; the coefficient memory is not cleared.
// One item at a time; a stalled result blocks new input.
`timescale 1ns / 1ps
module thermal_pid_power_budget_unit import tpb_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_level_enable_mask,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [15:0] in_temperature,
  input  logic [2:0]         in_severity,
  input  logic [15:0]        in_elapsed_ms,
  input  logic [3:0]         in_coef_kind,
  input  logic [2:0]         in_coef_level,
  input  logic signed [31:0] in_coef_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_budget_mw,
  output logic               out_unlimited,
  output logic [2:0]         out_target_level,
  output logic               out_budget_valid
);
  localparam int NUM_LEVELS = NUM_LEVELS_DEF;
  localparam int DEPTH = KINDS * NUM_LEVELS;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_r;
  logic [AW-1:0] raddr;
  logic [6:0] mask_r;
  state_t st_r, st_nxt;

  logic signed [31:0] integ_r, integ_nxt;
  logic signed [23:0] perr_r, perr_nxt;
  logic pvalid_r, pvalid_nxt;
  logic [LVL_W-1:0] t_r, t_nxt;
  logic signed [15:0] temp_r;
  logic [15:0] el_r;
  logic signed [23:0] err_r, err_nxt;
  logic signed [31:0] n_r, n_nxt;
  logic signed [63:0] acc_r, acc_nxt, inext_r, inext_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [31:0] ki_r, ki_nxt;
  logic signed [31:0] ovb_r, ovb_nxt;
  logic ov_unl_r, ov_unl_nxt, ov_bv_r, ov_bv_nxt, ov_valid_r, ov_valid_nxt;
  logic [2:0] ov_t_r, ov_t_nxt;
  logic in_xfer, wr_en, div_start, div_done;
  logic signed [63:0] div_q;
  logic [LVL_W-1:0] tsel;
  logic [KIND_W-1:0] rkind;
  logic signed [24:0] ediff;
  logic signed [63:0] nsum, mag;
  logic signed [31:0] wval;

  assign in_xfer = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE) || (ov_valid_r && out_stall);
  assign wr_en = in_xfer && in_opcode == OP_LOAD && in_coef_kind < KINDS[3:0]
                 && 32'(in_coef_level) < NUM_LEVELS;
  assign wval = 32'(signed'(in_coef_value[CW-1:0]));

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(32'(in_coef_level) * KINDS + 32'(in_coef_kind))] <= wval;
    rd_r <= mem[raddr];
  end
  assign raddr = AW'(32'(t_r) * KINDS + 32'(rkind));

  always_comb begin
    tsel = '0;
    for (int s = 0; s < NUM_LEVELS; s++) begin
      if (mask_r[s] && !(32'(tsel) > 32'(in_severity) && mask_r[tsel]))
        if (!(mask_r[tsel] && 32'(tsel) > 32'(in_severity))) tsel = LVL_W'(s);
    end
  end

  tpb_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(prod_r),
    .divisor(el_r), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    st_nxt = st_r; integ_nxt = integ_r; perr_nxt = perr_r; pvalid_nxt = pvalid_r;
    t_nxt = t_r; err_nxt = err_r; n_nxt = n_r; acc_nxt = acc_r;
    inext_nxt = inext_r; prod_nxt = prod_r; ki_nxt = ki_r; ovb_nxt = ovb_r;
    ov_unl_nxt = ov_unl_r; ov_bv_nxt = ov_bv_r; ov_t_nxt = ov_t_r;
    ov_valid_nxt = ov_valid_r && out_stall;
    div_start = 1'b0; rkind = K_THR;
    ediff = 25'(err_r) - 25'(perr_r);
    nsum = 64'(integ_r) + 64'(err_r);
    mag = inext_r < 0 ? -inext_r : inext_r;
    case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_opcode == OP_LOAD) begin
            ovb_nxt = '0; ov_unl_nxt = 1'b0; ov_t_nxt = '0; ov_bv_nxt = 1'b0;
            ov_valid_nxt = 1'b1;
          end else if (in_severity == 3'd0) begin
            ovb_nxt = 32'sh7fffffff; ov_unl_nxt = 1'b1; ov_t_nxt = '0;
            ov_bv_nxt = 1'b1; ov_valid_nxt = 1'b1;
          end else begin
            t_nxt = tsel; st_nxt = S_RD_THR;
          end
        end
      end
      S_RD_THR: begin rkind = K_THR; st_nxt = S_ERR; end
      S_ERR: begin
        prod_nxt = 64'(rd_r) - 64'(temp_r);
        if (prod_nxt > 64'sd8388607) err_nxt = 24'sh7fffff;
        else if (prod_nxt < -64'sd8388608) err_nxt = 24'sh800000;
        else err_nxt = prod_nxt[23:0];
        st_nxt = S_KP;
      end
      S_KP: begin rkind = err_r < 0 ? K_KPO : K_KPU; st_nxt = S_P; end
      S_P: begin
        prod_nxt = 64'(err_r) * 64'(rd_r);
        st_nxt = S_RD_KI;
      end
      S_RD_KI: begin
        acc_nxt = floor_shr24(prod_r); rkind = K_KI; st_nxt = S_I0;
      end
      S_I0: begin
        ki_nxt = rd_r; prod_nxt = 64'(integ_r) * 64'(rd_r);
        if (nsum > 64'sh7fffffff) n_nxt = 32'sh7fffffff;
        else if (nsum < -64'sh80000000) n_nxt = 32'sh80000000;
        else n_nxt = nsum[31:0];
        st_nxt = S_RD_ICUT;
      end
      S_RD_ICUT: begin
        inext_nxt = floor_shr24(prod_r);
        prod_nxt = 64'(n_r) * 64'(ki_r); rkind = K_ICUT; st_nxt = S_N;
      end
      S_N: begin
        if (64'(err_r) < 64'(rd_r)) st_nxt = S_IN;
        else begin acc_nxt = acc_r + inext_r; st_nxt = S_RD_KD; end
        ovb_nxt = '0;
      end
      S_IN: begin
        inext_nxt = floor_shr24(prod_r); st_nxt = S_RD_IMAX;
        prod_nxt = acc_r + inext_r;
      end
      S_RD_IMAX: begin rkind = K_IMAX; st_nxt = S_IMAX; end
      S_IMAX: begin
        if (mag < 64'(rd_r)) begin
          acc_nxt = acc_r + inext_r; integ_nxt = n_r;
        end else acc_nxt = prod_r;
        st_nxt = S_RD_KD;
      end
      S_RD_KD: begin rkind = K_KD; st_nxt = S_KD; end
      S_KD: begin
        prod_nxt = 64'(rd_r) * 64'(ediff);
        st_nxt = (pvalid_r && el_r != 16'd0) ? S_DIV : S_RD_BASE;
      end
      S_DIV: begin div_start = 1'b1; st_nxt = S_D; end
      S_D: begin
        if (div_done) begin
          acc_nxt = acc_r + floor_shr24(div_q); st_nxt = S_RD_BASE;
        end
      end
      S_RD_BASE: begin
        perr_nxt = err_r; pvalid_nxt = 1'b1; rkind = K_BASE; st_nxt = S_BASE;
      end
      S_BASE: begin acc_nxt = acc_r + 64'(rd_r); st_nxt = S_RD_MIN; end
      S_RD_MIN: begin rkind = K_MIN; st_nxt = S_MIN; end
      S_MIN: begin
        if (acc_r < 64'(rd_r)) acc_nxt = 64'(rd_r);
        st_nxt = S_RD_MAX;
      end
      S_RD_MAX: begin rkind = K_MAX; st_nxt = S_MAX; end
      S_MAX: begin
        if (acc_r > 64'(rd_r)) acc_nxt = 64'(rd_r);
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (acc_r > 64'sh7fffffff) ovb_nxt = 32'sh7fffffff;
        else if (acc_r < -64'sh80000000) ovb_nxt = 32'sh80000000;
        else ovb_nxt = acc_r[31:0];
        ov_unl_nxt = 1'b0; ov_t_nxt = 3'(t_r); ov_bv_nxt = 1'b1;
        ov_valid_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; integ_r <= '0; perr_r <= '0; pvalid_r <= 1'b0;
      mask_r <= '0; ov_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; integ_r <= integ_nxt; perr_r <= perr_nxt;
      pvalid_r <= pvalid_nxt; ov_valid_r <= ov_valid_nxt;
      if (cfg_we) mask_r <= cfg_level_enable_mask & 7'((1 << NUM_LEVELS) - 1);
    end
    t_r <= t_nxt; err_r <= err_nxt; n_r <= n_nxt; acc_r <= acc_nxt;
    inext_r <= inext_nxt; prod_r <= prod_nxt; ki_r <= ki_nxt; ovb_r <= ovb_nxt;
    ov_unl_r <= ov_unl_nxt; ov_bv_r <= ov_bv_nxt; ov_t_r <= ov_t_nxt;
    if (in_xfer) begin temp_r <= in_temperature; el_r <= in_elapsed_ms; end
  end

  assign out_valid = ov_valid_r;
  assign out_budget_mw = ovb_r;
  assign out_unlimited = ov_unl_r;
  assign out_target_level = ov_t_r;
  assign out_budget_valid = ov_bv_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_budget_mw))
    else $error("result lost under stall");
  a_unl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unlimited |-> out_budget_valid && out_target_level == 3'd0)
    else $error("unlimited result malformed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> in_stall)
    else $error("input taken while busy");
endmodule
